// File: hdl/rwm_pkg.sv
// shared types and constants of the random waypoint mover
`timescale 1ns / 1ps
`default_nettype none
package rwm_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int RAND_BITS  = 16;
    localparam int POS_BITS   = COORD_BITS + FRAC_BITS;
    localparam int CFG_BITS   = 16;
    localparam int IDX_BITS   = 3;
    localparam int SQRT_STEPS = POS_BITS + 1;
    localparam int DIV_STEPS  = POS_BITS;
    localparam int CNT_BITS   = 5;

    // register indexes
    localparam logic [IDX_BITS-1:0] REG_AREA_W  = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_AREA_H  = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_START_X = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_START_Y = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_BASE_SP = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_SPREAD  = 3'd5;
    localparam logic [IDX_BITS-1:0] REG_TICK    = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE, S_WX, S_WY, S_SP, S_SPST, S_LEN, S_AX, S_AY,
        S_SQST, S_SQRT, S_VX, S_VY, S_DVST, S_DIV, S_VEL, S_MOVE
    } t_state;

    typedef enum logic [2:0] {
        M_WX, M_WY, M_SP, M_LEN, M_AX2, M_AY2, M_VX, M_VY
    } t_mul_sel;

    typedef struct packed {
        logic     take;
        t_mul_sel mul_sel;
        logic     st_wx;
        logic     st_wy;
        logic     st_sp;
        logic     st_len;
        logic     st_ax2;
        logic     st_ay2;
        logic     sq_step;
        logic     st_nx;
        logic     st_ny;
        logic     dv_step;
        logic     st_vel;
        logic     move;
    } t_cmd;

    typedef struct packed {
        logic arrive;
        logic drawn;
        logic out_busy;
    } t_status;

endpackage
`default_nettype wire

// File: hdl/rwm_in_if.sv
// input channel: one tick word with three random draws
`timescale 1ns / 1ps
`default_nettype none
interface rwm_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] draw_x;
    logic [15:0] draw_y;
    logic [15:0] draw_speed;

    modport source (output valid, draw_x, draw_y, draw_speed, input ready);
    modport sink   (input valid, draw_x, draw_y, draw_speed, output ready);
endinterface
`default_nettype wire

// File: hdl/rwm_out_if.sv
// output channel: position and speed after one tick
`timescale 1ns / 1ps
`default_nettype none
interface rwm_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] pos_x;
    logic [23:0] pos_y;
    logic [15:0] cur_speed;
    logic        new_waypoint;

    modport source (output valid, pos_x, pos_y, cur_speed, new_waypoint, input ready);
    modport sink   (input valid, pos_x, pos_y, cur_speed, new_waypoint, output ready);
endinterface
`default_nettype wire

// File: hdl/rwm_ctrl.sv
// sequencer for one mobility tick
`timescale 1ns / 1ps
`default_nettype none
module rwm_ctrl
    import rwm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state                r_state, n_state;
    logic   [CNT_BITS-1:0] r_cnt, n_cnt;

    // state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.mul_sel = M_WX;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    n_state = i_status.arrive ? S_WX : S_LEN;
                end
            end
            S_WX: begin
                o_cmd.mul_sel = M_WX;
                n_state = S_WY;
            end
            S_WY: begin
                o_cmd.mul_sel = M_WY;
                o_cmd.st_wx = 1'b1;
                n_state = S_SP;
            end
            S_SP: begin
                o_cmd.mul_sel = M_SP;
                o_cmd.st_wy = 1'b1;
                n_state = S_SPST;
            end
            S_SPST: begin
                o_cmd.st_sp = 1'b1;
                n_state = S_LEN;
            end
            S_LEN: begin
                o_cmd.mul_sel = M_LEN;
                n_state = S_AX;
            end
            S_AX: begin
                o_cmd.mul_sel = M_AX2;
                o_cmd.st_len = 1'b1;
                n_state = S_AY;
            end
            S_AY: begin
                o_cmd.mul_sel = M_AY2;
                o_cmd.st_ax2 = 1'b1;
                n_state = S_SQST;
            end
            S_SQST: begin
                o_cmd.st_ay2 = 1'b1;
                n_cnt = '0;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sq_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(SQRT_STEPS - 1)) begin
                    n_state = i_status.drawn ? S_VX : S_MOVE;
                end
            end
            S_VX: begin
                o_cmd.mul_sel = M_VX;
                n_state = S_VY;
            end
            S_VY: begin
                o_cmd.mul_sel = M_VY;
                o_cmd.st_nx = 1'b1;
                n_state = S_DVST;
            end
            S_DVST: begin
                o_cmd.st_ny = 1'b1;
                n_cnt = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.dv_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(DIV_STEPS - 1)) begin
                    n_state = S_VEL;
                end
            end
            S_VEL: begin
                o_cmd.st_vel = 1'b1;
                n_state = S_MOVE;
            end
            S_MOVE: begin
                if (!i_status.out_busy) begin
                    o_cmd.move = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: hdl/rwm_datapath.sv
// mover state, shared multiplier, square root and dividers, output register
`timescale 1ns / 1ps
`default_nettype none
module rwm_datapath
    import rwm_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [CFG_BITS-1:0] i_cfg_data,
    input  wire t_cmd                i_cmd,
    output t_status                  o_status,
    input  wire logic [15:0]         i_draw_x,
    input  wire logic [15:0]         i_draw_y,
    input  wire logic [15:0]         i_draw_speed,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [POS_BITS-1:0]      o_pos_x,
    output logic [POS_BITS-1:0]      o_pos_y,
    output logic [15:0]              o_cur_speed,
    output logic                     o_new_waypoint
);

    localparam int PROD_BITS = 2 * POS_BITS;
    localparam int SQV_BITS  = 2 * SQRT_STEPS;
    localparam int REM_BITS  = SQRT_STEPS + 2;
    localparam int DR_BITS   = POS_BITS + 1;

    // configuration
    logic [15:0] r_area_w, r_area_h, r_spread, r_tick;
    // mover state
    logic [POS_BITS-1:0]   r_pos_x, r_pos_y;
    logic [COORD_BITS-1:0] r_wp_x, r_wp_y;
    logic [15:0]           r_speed;
    logic signed [POS_BITS:0] r_vel_x, r_vel_y;
    // tick work registers
    logic [RAND_BITS-1:0]  r_dx, r_dy, r_ds;
    logic                  r_drawn;
    logic [PROD_BITS-1:0]  r_prod;
    logic [POS_BITS-1:0]   r_len;
    logic [PROD_BITS:0]    r_sum;
    logic [SQV_BITS-1:0]   r_sq_val;
    logic [REM_BITS-1:0]   r_sq_rem;
    logic [SQRT_STEPS-1:0] r_sq_root;
    logic [DR_BITS-1:0]    r_rem_x, r_rem_y;
    logic [POS_BITS-1:0]   r_q_x, r_q_y;
    logic                  r_neg_x, r_neg_y;
    // output word
    logic                  r_ov;
    logic [POS_BITS-1:0]   r_opx, r_opy;
    logic [15:0]           r_osp;
    logic                  r_onw;

    // rounded position against waypoint
    logic [POS_BITS:0]   w_rnd_x, w_rnd_y;
    assign w_rnd_x = {1'b0, r_pos_x} + (POS_BITS+1)'(1 << (FRAC_BITS - 1));
    assign w_rnd_y = {1'b0, r_pos_y} + (POS_BITS+1)'(1 << (FRAC_BITS - 1));
    assign o_status.arrive = (w_rnd_x[POS_BITS:FRAC_BITS] == {1'b0, r_wp_x})
                          && (w_rnd_y[POS_BITS:FRAC_BITS] == {1'b0, r_wp_y});
    assign o_status.drawn    = r_drawn;
    assign o_status.out_busy = r_ov && !i_ready;

    // distance magnitudes to the waypoint
    logic [POS_BITS-1:0] w_wpf_x, w_wpf_y, w_ax, w_ay;
    logic                w_nx, w_ny;
    assign w_wpf_x = {r_wp_x, {FRAC_BITS{1'b0}}};
    assign w_wpf_y = {r_wp_y, {FRAC_BITS{1'b0}}};
    assign w_nx = w_wpf_x < r_pos_x;
    assign w_ny = w_wpf_y < r_pos_y;
    assign w_ax = w_nx ? r_pos_x - w_wpf_x : w_wpf_x - r_pos_x;
    assign w_ay = w_ny ? r_pos_y - w_wpf_y : w_wpf_y - r_pos_y;

    // shared multiplier operands
    logic [16:0]         w_aw1, w_ah1;
    logic [POS_BITS-1:0] w_ma, w_mb;
    assign w_aw1 = {1'b0, r_area_w} + 17'd1;
    assign w_ah1 = {1'b0, r_area_h} + 17'd1;
    always_comb begin
        case (i_cmd.mul_sel)
            M_WX:    begin w_ma = POS_BITS'(r_dx);    w_mb = POS_BITS'(w_aw1);    end
            M_WY:    begin w_ma = POS_BITS'(r_dy);    w_mb = POS_BITS'(w_ah1);    end
            M_SP:    begin w_ma = POS_BITS'(r_ds);    w_mb = POS_BITS'(r_spread); end
            M_LEN:   begin w_ma = POS_BITS'(r_speed); w_mb = POS_BITS'(r_tick);   end
            M_AX2:   begin w_ma = w_ax;               w_mb = w_ax;                end
            M_AY2:   begin w_ma = w_ay;               w_mb = w_ay;                end
            M_VX:    begin w_ma = r_len;              w_mb = w_ax;                end
            M_VY:    begin w_ma = r_len;              w_mb = w_ay;                end
            default: begin w_ma = '0;                 w_mb = '0;                  end
        endcase
    end

    // speed draw with saturation
    logic signed [17:0] w_spd;
    logic [15:0]        w_spd_sat;
    assign w_spd = $signed({2'b00, r_speed}) - $signed({3'b000, r_spread[15:1]})
                 + $signed({2'b00, r_prod[RAND_BITS +: 16]});
    assign w_spd_sat = w_spd < 0 ? 16'd0 : (w_spd > 18'sd65535 ? 16'hFFFF : w_spd[15:0]);

    // one square root digit
    logic [REM_BITS+1:0] w_sq_t, w_sq_trial;
    assign w_sq_t     = {r_sq_rem, r_sq_val[SQV_BITS-1 -: 2]};
    assign w_sq_trial = {2'b00, r_sq_root, 2'b01};

    // one quotient bit per divider
    logic [DR_BITS:0] w_dx_t, w_dy_t, w_den;
    assign w_den  = {1'b0, r_sq_root};
    assign w_dx_t = {r_rem_x, r_q_x[POS_BITS-1]};
    assign w_dy_t = {r_rem_y, r_q_y[POS_BITS-1]};

    // position update with clamp
    logic [POS_BITS-1:0]        w_hi_x, w_hi_y, w_new_x, w_new_y;
    logic signed [POS_BITS+1:0] w_px, w_py;
    logic                       w_snap;
    assign w_hi_x = {r_area_w, {FRAC_BITS{1'b0}}};
    assign w_hi_y = {r_area_h, {FRAC_BITS{1'b0}}};
    assign w_px = $signed({2'b00, r_pos_x}) + (POS_BITS+2)'(r_vel_x);
    assign w_py = $signed({2'b00, r_pos_y}) + (POS_BITS+2)'(r_vel_y);
    assign w_snap = r_sq_root < {1'b0, r_len};
    always_comb begin
        if (w_snap) begin
            w_new_x = w_wpf_x > w_hi_x ? w_hi_x : w_wpf_x;
            w_new_y = w_wpf_y > w_hi_y ? w_hi_y : w_wpf_y;
        end else begin
            if (w_px < 0) begin
                w_new_x = '0;
            end else if (w_px > $signed({2'b00, w_hi_x})) begin
                w_new_x = w_hi_x;
            end else begin
                w_new_x = w_px[POS_BITS-1:0];
            end
            if (w_py < 0) begin
                w_new_y = '0;
            end else if (w_py > $signed({2'b00, w_hi_y})) begin
                w_new_y = w_hi_y;
            end else begin
                w_new_y = w_py[POS_BITS-1:0];
            end
        end
    end

    // configuration and mover state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_w <= 16'd1000;
            r_area_h <= 16'd1000;
            r_spread <= 16'd512;
            r_tick   <= 16'd256;
            r_pos_x  <= '0;
            r_pos_y  <= '0;
            r_wp_x   <= '0;
            r_wp_y   <= '0;
            r_speed  <= 16'd256;
            r_vel_x  <= '0;
            r_vel_y  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_AREA_W:  r_area_w <= i_cfg_data;
                    REG_AREA_H:  r_area_h <= i_cfg_data;
                    REG_START_X: begin
                        r_wp_x  <= i_cfg_data;
                        r_pos_x <= {i_cfg_data, {FRAC_BITS{1'b0}}};
                    end
                    REG_START_Y: begin
                        r_wp_y  <= i_cfg_data;
                        r_pos_y <= {i_cfg_data, {FRAC_BITS{1'b0}}};
                    end
                    REG_BASE_SP: r_speed  <= i_cfg_data;
                    REG_SPREAD:  r_spread <= i_cfg_data;
                    REG_TICK:    r_tick   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.st_wx) r_wp_x <= r_prod[RAND_BITS +: COORD_BITS];
            if (i_cmd.st_wy) r_wp_y <= r_prod[RAND_BITS +: COORD_BITS];
            if (i_cmd.st_sp) r_speed <= w_spd_sat;
            if (i_cmd.st_vel) begin
                if (r_sq_root == '0) begin
                    r_vel_x <= '0;
                    r_vel_y <= '0;
                end else begin
                    r_vel_x <= r_neg_x ? -$signed({1'b0, r_q_x}) : $signed({1'b0, r_q_x});
                    r_vel_y <= r_neg_y ? -$signed({1'b0, r_q_y}) : $signed({1'b0, r_q_y});
                end
            end
            if (i_cmd.move) begin
                r_pos_x <= w_new_x;
                r_pos_y <= w_new_y;
            end
        end
    end

    // draws, product and arrival flag of the current tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drawn <= 1'b0;
        end else if (i_cmd.take) begin
            r_drawn <= o_status.arrive;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        if (i_cmd.take) begin
            r_dx <= i_draw_x[RAND_BITS-1:0];
            r_dy <= i_draw_y[RAND_BITS-1:0];
            r_ds <= i_draw_speed[RAND_BITS-1:0];
        end
        if (i_cmd.st_len) r_len <= r_prod[(16 - FRAC_BITS) +: POS_BITS];
        if (i_cmd.st_ax2) r_sum <= {1'b0, r_prod};
        // square root, two radicand bits a step
        if (i_cmd.st_ay2) begin
            r_sq_val  <= SQV_BITS'(r_sum + {1'b0, r_prod});
            r_sq_rem  <= '0;
            r_sq_root <= '0;
        end else if (i_cmd.sq_step) begin
            r_sq_val <= {r_sq_val[SQV_BITS-3:0], 2'b00};
            if (w_sq_t >= w_sq_trial) begin
                r_sq_rem  <= REM_BITS'(w_sq_t - w_sq_trial);
                r_sq_root <= {r_sq_root[SQRT_STEPS-2:0], 1'b1};
            end else begin
                r_sq_rem  <= REM_BITS'(w_sq_t);
                r_sq_root <= {r_sq_root[SQRT_STEPS-2:0], 1'b0};
            end
        end
        // restoring dividers, quotient fits in the low half
        if (i_cmd.st_nx) begin
            r_rem_x <= {1'b0, r_prod[PROD_BITS-1 -: POS_BITS]};
            r_q_x   <= r_prod[POS_BITS-1:0];
        end
        if (i_cmd.st_ny) begin
            r_rem_y <= {1'b0, r_prod[PROD_BITS-1 -: POS_BITS]};
            r_q_y   <= r_prod[POS_BITS-1:0];
            r_neg_x <= w_nx;
            r_neg_y <= w_ny;
        end
        if (i_cmd.dv_step) begin
            if (w_dx_t >= w_den) begin
                r_rem_x <= DR_BITS'(w_dx_t - w_den);
                r_q_x   <= {r_q_x[POS_BITS-2:0], 1'b1};
            end else begin
                r_rem_x <= DR_BITS'(w_dx_t);
                r_q_x   <= {r_q_x[POS_BITS-2:0], 1'b0};
            end
            if (w_dy_t >= w_den) begin
                r_rem_y <= DR_BITS'(w_dy_t - w_den);
                r_q_y   <= {r_q_y[POS_BITS-2:0], 1'b1};
            end else begin
                r_rem_y <= DR_BITS'(w_dy_t);
                r_q_y   <= {r_q_y[POS_BITS-2:0], 1'b0};
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.move) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.move) begin
            r_opx <= w_new_x;
            r_opy <= w_new_y;
            r_osp <= r_speed;
            r_onw <= r_drawn;
        end
    end

    assign o_valid        = r_ov;
    assign o_pos_x        = r_opx;
    assign o_pos_y        = r_opy;
    assign o_cur_speed    = r_osp;
    assign o_new_waypoint = r_onw;

endmodule
`default_nettype wire

// File: hdl/random_waypoint_mover.sv
// one tick word at a time: the next is taken in idle once the last is done; the work per word is
// set by the 25-step square root and the 24-step dividers
// the result waits in an output register; the block holds in its last step while it is full and not taken
// synchronous active-low reset loads the register defaults and puts the mover at position zero
`timescale 1ns / 1ps
`default_nettype none
module random_waypoint_mover
    import rwm_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [CFG_BITS-1:0] i_cfg_data,
    rwm_in_if.sink                   i_in,
    rwm_out_if.source                o_out
);

    t_cmd    w_cmd;
    t_status w_status;

    // sequencer
    rwm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in.valid),
        .o_ready  (i_in.ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // datapath
    rwm_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_draw_x       (i_in.draw_x),
        .i_draw_y       (i_in.draw_y),
        .i_draw_speed   (i_in.draw_speed),
        .o_valid        (o_out.valid),
        .i_ready        (o_out.ready),
        .o_pos_x        (o_out.pos_x),
        .o_pos_y        (o_out.pos_y),
        .o_cur_speed    (o_out.cur_speed),
        .o_new_waypoint (o_out.new_waypoint)
    );

`ifndef NO_ASSERTIONS
    // an accepted word keeps the block busy in the next cycle
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken again right after accept");

    // no result appears in the cycle after an accept
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !$rose(o_out.valid))
        else $error("result rose right after accept");

    // a stalled result holds its position
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> ($stable(o_out.pos_x) && $stable(o_out.pos_y)))
        else $error("stalled result changed");
`endif

endmodule
`default_nettype wire
